[design/csm_pkg.sv]
package csm_pkg;

    localparam int MAX_COLS        = 4096;
    localparam int MAX_ROWS        = 4096;
    localparam int VALUE_WIDTH     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int ACC_WIDTH       = 64;
    localparam int COL_WIDTH       = $clog2(MAX_COLS);
    localparam int ROW_WIDTH       = $clog2(MAX_ROWS);
    localparam int CFG_WIDTH       = 13;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [1:0]
    {
        FUNC_LOAD  = 2'd0,
        FUNC_TERM  = 2'd1,
        FUNC_EMPTY = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0]
    {
        REG_NUM_ROWS = 2'd0,
        REG_NUM_COLS = 2'd1
    } reg_index_t;

    typedef struct packed
    {
        logic [1:0]                    func;
        logic [COL_WIDTH-1:0]          vector_index;
        logic signed [VALUE_WIDTH-1:0] vector_value;
        logic [COL_WIDTH-1:0]          column_index;
        logic signed [VALUE_WIDTH-1:0] matrix_value;
        logic                          row_end;
    } item_t;

    typedef struct packed
    {
        logic [ROW_WIDTH-1:0]          row_index;
        logic signed [VALUE_WIDTH-1:0] row_sum;
        logic                          saturated;
        logic                          index_error;
        logic                          last_row;
    } result_t;

    // Control that rides along with one matrix beat through the datapath.
    typedef struct packed
    {
        logic close;
        logic term;
        logic err;
    } term_ctrl_t;

    // A finished row on its way to rounding.
    typedef struct packed
    {
        logic [ROW_WIDTH-1:0]        row_index;
        logic signed [ACC_WIDTH-1:0] acc;
        logic                        index_error;
        logic                        last_row;
    } closed_row_t;

endpackage

[design/csm_vec_mem.sv]
module csm_vec_mem
(
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [csm_pkg::COL_WIDTH-1:0]         wr_addr,
    input  logic signed [csm_pkg::VALUE_WIDTH-1:0] wr_data,
    input  logic                                  rd_en,
    input  logic [csm_pkg::COL_WIDTH-1:0]         rd_addr,
    output logic signed [csm_pkg::VALUE_WIDTH-1:0] rd_data
);

    logic signed [csm_pkg::VALUE_WIDTH-1:0] mem [csm_pkg::MAX_COLS];
    logic signed [csm_pkg::VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/csm_accum.sv]
module csm_accum
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   take,
    input  csm_pkg::term_ctrl_t                    ctrl,
    input  logic signed [csm_pkg::VALUE_WIDTH-1:0] matrix_value,
    input  logic signed [csm_pkg::VALUE_WIDTH-1:0] x_value,
    input  logic [csm_pkg::CFG_WIDTH-1:0]          rows_eff,
    output logic                                   ready,
    output logic                                   closed_valid,
    output csm_pkg::closed_row_t                   closed,
    input  logic                                   down_ready
);

    localparam int AW = csm_pkg::ACC_WIDTH;
    localparam int CW = csm_pkg::CFG_WIDTH;
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // First stage: operand and stored vector entry.
    logic                                   p1_valid_reg;
    csm_pkg::term_ctrl_t                    p1_ctrl_reg;
    logic signed [csm_pkg::VALUE_WIDTH-1:0] p1_a_reg;

    // Second stage: product.
    logic                                   p2_valid_reg;
    csm_pkg::term_ctrl_t                    p2_ctrl_reg;
    logic signed [AW-1:0]                   p2_prod_reg;

    // Row state.
    logic signed [AW-1:0]                   acc_reg;
    logic signed [AW-1:0]                   acc_next;
    logic                                   row_err_reg;
    logic [csm_pkg::ROW_WIDTH-1:0]          counter_reg;
    logic [csm_pkg::ROW_WIDTH-1:0]          counter_next;

    logic                                   closed_valid_reg;
    csm_pkg::closed_row_t                   closed_reg;

    logic                 c_ready;
    logic                 p2_ready;
    logic                 p2_fire;
    logic                 p1_fire;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] raw_sum;
    logic                 overflow;
    logic                 last;
    logic                 wrap;
    logic                 close_now;

    assign c_ready  = !closed_valid_reg || down_ready;
    assign p2_ready = !p2_valid_reg || !p2_ctrl_reg.close || c_ready;
    assign p2_fire  = p2_valid_reg && p2_ready;
    assign ready    = !p1_valid_reg || p2_ready;
    assign p1_fire  = p1_valid_reg && p2_ready;
    assign close_now = p2_fire && p2_ctrl_reg.close;

    // Saturating accumulate at the 64-bit signed limits.
    always_comb
    begin
        addend   = p2_ctrl_reg.term ? p2_prod_reg : '0;
        raw_sum  = acc_reg + addend;
        overflow = (acc_reg[AW-1] == addend[AW-1]) && (raw_sum[AW-1] != acc_reg[AW-1]);
        if (overflow)
        begin
            acc_next = acc_reg[AW-1] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_next = raw_sum;
        end
    end

    always_comb
    begin
        last = ({1'b0, counter_reg} == (rows_eff - CW'(1)));
        wrap = last || (({1'b0, counter_reg} + CW'(1)) >= rows_eff);
        counter_next = wrap ? '0 : counter_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            closed_valid_reg <= 1'b0;
            acc_reg          <= '0;
            row_err_reg      <= 1'b0;
            counter_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_fire)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (p1_fire)
            begin
                p2_valid_reg <= 1'b1;
            end
            else if (p2_fire)
            begin
                p2_valid_reg <= 1'b0;
            end

            if (close_now)
            begin
                closed_valid_reg <= 1'b1;
            end
            else if (down_ready)
            begin
                closed_valid_reg <= 1'b0;
            end

            if (p2_fire)
            begin
                if (p2_ctrl_reg.close)
                begin
                    acc_reg     <= '0;
                    row_err_reg <= 1'b0;
                    counter_reg <= counter_next;
                end
                else
                begin
                    acc_reg     <= acc_next;
                    row_err_reg <= row_err_reg || p2_ctrl_reg.err;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p1_ctrl_reg <= ctrl;
            p1_a_reg    <= matrix_value;
        end
        if (p1_fire)
        begin
            p2_ctrl_reg <= p1_ctrl_reg;
            p2_prod_reg <= AW'(p1_a_reg) * AW'(x_value);
        end
        if (close_now)
        begin
            closed_reg.row_index   <= counter_reg;
            closed_reg.acc         <= acc_next;
            closed_reg.index_error <= row_err_reg || p2_ctrl_reg.err;
            closed_reg.last_row    <= last;
        end
    end

    assign closed_valid = closed_valid_reg;
    assign closed       = closed_reg;

endmodule

[design/csm_round_sat.sv]
module csm_round_sat
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 closed_valid,
    input  csm_pkg::closed_row_t closed,
    output logic                 ready,
    output logic                 result_valid,
    output csm_pkg::result_t     result,
    input  logic                 result_stall
);

    localparam int VW = csm_pkg::VALUE_WIDTH;
    localparam int FB = csm_pkg::FRAC_BITS;
    localparam int AW = csm_pkg::ACC_WIDTH;
    localparam int QW = AW - FB + 1;

    logic                    result_valid_reg;
    csm_pkg::result_t        result_reg;
    logic [AW-FB-1:0]        whole;
    logic signed [QW-1:0]    q;
    logic                    fits;
    logic signed [VW-1:0]    sum;

    // Round half up: floor of the Q16.16 value plus the top dropped bit.
    always_comb
    begin
        whole = closed.acc[AW-1:FB];
        q     = $signed({whole[AW-FB-1], whole}) + $signed({{(QW-1){1'b0}}, closed.acc[FB-1]});
        fits  = (&q[QW-1:VW-1]) || !(|q[QW-1:VW-1]);
        if (fits)
        begin
            sum = q[VW-1:0];
        end
        else
        begin
            sum = q[QW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
    end

    assign ready = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            result_valid_reg <= closed_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && closed_valid)
        begin
            result_reg.row_index   <= closed.row_index;
            result_reg.row_sum     <= sum;
            result_reg.saturated   <= !fits;
            result_reg.index_error <= closed.index_error;
            result_reg.last_row    <= closed.last_row;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/csr_sparse_matvec.sv]
// A row-closing matrix beat passes the operand, product, closed-row and result registers.
// One input beat per cycle unless stalled; the single multiply-accumulate loop sets it.
// Vector loads are written to the vector memory at the edge they are accepted.
// Reset (rst_n, asynchronous, active low) clears the pipeline, the accumulator, the row
// counter and the error flag, and sets num_rows and num_cols to 4096. The vector memory
// is not cleared; it holds no defined value until an entry is loaded.
module csr_sparse_matvec
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  csm_pkg::item_t                        item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output csm_pkg::result_t                      result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [csm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [csm_pkg::CFG_WIDTH-1:0]         cfg_data
);

    localparam int CW = csm_pkg::CFG_WIDTH;

    // Configuration registers; writes are taken every cycle. Software must write them
    // only while the block is idle (not enforced); the datapath reads them unstaged.
    logic [CW-1:0] num_rows_reg;
    logic [CW-1:0] num_cols_reg;
    logic [CW-1:0] rows_eff;
    logic [CW-1:0] cols_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CW'(csm_pkg::MAX_ROWS);
            num_cols_reg <= CW'(csm_pkg::MAX_COLS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                csm_pkg::REG_NUM_ROWS: num_rows_reg <= cfg_data;
                csm_pkg::REG_NUM_COLS: num_cols_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // A zero row count behaves as one row; counts beyond the limits are clipped.
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows_eff = CW'(1);
        end
        else if (num_rows_reg > CW'(csm_pkg::MAX_ROWS))
        begin
            rows_eff = CW'(csm_pkg::MAX_ROWS);
        end
        else
        begin
            rows_eff = num_rows_reg;
        end

        if (num_cols_reg > CW'(csm_pkg::MAX_COLS))
        begin
            cols_eff = CW'(csm_pkg::MAX_COLS);
        end
        else
        begin
            cols_eff = num_cols_reg;
        end
    end

    // Input decode. A load beat goes straight into the vector memory and leaves
    // nothing in the pipeline. A matrix beat reads its vector entry in the same
    // cycle, so a load followed at once by a term on that column sees the new value.
    logic                accept;
    logic                is_load;
    logic                is_term;
    logic                is_empty;
    logic                col_err;
    logic                accum_ready;
    csm_pkg::term_ctrl_t ctrl;

    logic signed [csm_pkg::VALUE_WIDTH-1:0] x_value;

    assign accept   = item_valid && !item_stall;
    assign is_load  = (item.func == csm_pkg::FUNC_LOAD);
    assign is_term  = (item.func == csm_pkg::FUNC_TERM);
    assign is_empty = (item.func == csm_pkg::FUNC_EMPTY);
    assign col_err  = ({1'b0, item.column_index} >= cols_eff);

    always_comb
    begin
        ctrl.close = is_empty || (is_term && item.row_end);
        ctrl.term  = is_term && !col_err;
        ctrl.err   = is_term && col_err;
    end

    // Stall only when the result beat is held, the closed-row register is full,
    // the product stage holds a closing beat and the operand stage is occupied.
    assign item_stall = !accum_ready;

    csm_vec_mem u_vec_mem
    (
        .clk     (clk),
        .wr_en   (accept && is_load),
        .wr_addr (item.vector_index),
        .wr_data (item.vector_value),
        .rd_en   (accept && is_term),
        .rd_addr (item.column_index),
        .rd_data (x_value)
    );

    logic                 closed_valid;
    csm_pkg::closed_row_t closed;
    logic                 round_ready;

    // Multiply, then accumulate; a closing beat hands the row sum on.
    csm_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (accept && (is_term || is_empty)),
        .ctrl         (ctrl),
        .matrix_value (item.matrix_value),
        .x_value      (x_value),
        .rows_eff     (rows_eff),
        .ready        (accum_ready),
        .closed_valid (closed_valid),
        .closed       (closed),
        .down_ready   (round_ready)
    );

    // Round the Q32.32 sum to Q16.16, saturate and hold it in the result register.
    csm_round_sat u_round_sat
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .closed_valid (closed_valid),
        .closed       (closed),
        .ready        (round_ready),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

[design/csm_checker.sv]
module csm_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_stall,
    input logic                                result_valid,
    input logic                                result_stall,
    input csm_pkg::result_t                    result,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [csm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input logic [csm_pkg::CFG_WIDTH-1:0]       cfg_data
);

    localparam int CW = csm_pkg::CFG_WIDTH;
    localparam int VW = csm_pkg::VALUE_WIDTH;

    logic [CW-1:0] rows_reg;
    logic [CW-1:0] rows_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CW'(csm_pkg::MAX_ROWS);
        end
        else if (cfg_valid && cfg_ready && (cfg_index == csm_pkg::REG_NUM_ROWS))
        begin
            rows_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (rows_reg == '0)
        begin
            rows_eff = CW'(1);
        end
        else if (rows_reg > CW'(csm_pkg::MAX_ROWS))
        begin
            rows_eff = CW'(csm_pkg::MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_reg;
        end
    end

    // A held result beat stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // The input side only backs up when the result side is holding a beat.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");

    // A clipped sum sits at one of the two limits.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.row_sum == {1'b0, {(VW-1){1'b1}}}) ||
            (result.row_sum == {1'b1, {(VW-1){1'b0}}}))
        else $error("saturated sum not at a limit");

    // The final row of a product is the one numbered one below the row count.
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_row |-> ({1'b0, result.row_index} == rows_eff - CW'(1)))
        else $error("last_row on the wrong row");

endmodule

bind csr_sparse_matvec csm_checker u_checker (.*);

[test/csr_sparse_matvec_tb.sv]
module csr_sparse_matvec_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int TARGET_BEATS   = 1250;
    // A closing row passes the operand, product, closed-row and result registers; this
    // covers any beat still in flight that produces no result.
    localparam int DRAIN_CYCLES   = 8;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int REPORT_LIMIT   = 10;

    // The one function code that the package leaves unnamed; the block ignores it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam longint SUM_MAX = (longint'(1) <<< (csm_pkg::VALUE_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< (csm_pkg::VALUE_WIDTH - 1));
    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

    logic                                clk;
    logic                                rst_n;
    logic                                item_valid;
    logic                                item_stall;
    csm_pkg::item_t                      item;
    logic                                result_valid;
    logic                                result_stall;
    csm_pkg::result_t                    result;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [csm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [csm_pkg::CFG_WIDTH-1:0]       cfg_data;

    csr_sparse_matvec u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // One row of the directed table: either an input beat, optionally with its row
    // result written out by hand, or a register write.
    typedef enum logic { STEP_BEAT, STEP_REG } step_kind_t;

    typedef struct
    {
        step_kind_t                    kind;
        csm_pkg::item_t                beat;
        csm_pkg::reg_index_t           reg_sel;
        logic [csm_pkg::CFG_WIDTH-1:0] reg_val;
        bit                            typed;
        csm_pkg::result_t              want;
    } plan_row_t;

    // The directed table, walked in order.
    plan_row_t plan[$];

    // Row sums that the block still owes us, oldest first.
    csm_pkg::result_t pending_rows[$];

    int  beats_sent;
    int  bad_results;
    bit  squeeze_go;

    // Our own copy of the block's state, advanced once per accepted beat.
    logic signed [csm_pkg::VALUE_WIDTH-1:0] x_mem [csm_pkg::MAX_COLS];
    bit                                     x_loaded [csm_pkg::MAX_COLS];
    longint                                 acc_q3232;
    int unsigned                            row_cnt;
    bit                                     row_bad_col;
    logic [csm_pkg::CFG_WIDTH-1:0]          reg_rows;
    logic [csm_pkg::CFG_WIDTH-1:0]          reg_cols;

    // The accumulator clips at the 64-bit signed limits on every addition, and later
    // terms keep adding to the clipped value.
    function automatic longint add_clipped(input longint a, input longint b);
        longint s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
            return ACC_MAX;
        if (a[63] && b[63] && !s[63])
            return ACC_MIN;
        return s;
    endfunction

    // Closes the current row: rounds Q32.32 to Q16.16 to nearest with ties going up,
    // clips to the value range, tags the last row of the product and restarts the
    // count. A row count register of zero behaves as one, an oversize one as the
    // maximum, and a count that has run past a lowered register wraps to zero.
    function automatic csm_pkg::result_t close_row_sum();
        csm_pkg::result_t r;
        longint           q;
        int unsigned      rows;
        bit               clip;
        q = acc_q3232 >>> csm_pkg::FRAC_BITS;
        if (acc_q3232[csm_pkg::FRAC_BITS-1])
            q = q + 1;
        clip = 1'b0;
        if (q > SUM_MAX)
        begin
            q    = SUM_MAX;
            clip = 1'b1;
        end
        if (q < SUM_MIN)
        begin
            q    = SUM_MIN;
            clip = 1'b1;
        end
        rows = (reg_rows == 0) ? 1 :
               ((reg_rows > csm_pkg::MAX_ROWS) ? csm_pkg::MAX_ROWS : reg_rows);
        r.row_index   = csm_pkg::ROW_WIDTH'(row_cnt);
        r.row_sum     = q[csm_pkg::VALUE_WIDTH-1:0];
        r.saturated   = clip;
        r.index_error = row_bad_col;
        r.last_row    = (row_cnt == rows - 1);
        if (r.last_row || row_cnt + 1 >= rows)
            row_cnt = 0;
        else
            row_cnt = row_cnt + 1;
        acc_q3232   = 0;
        row_bad_col = 1'b0;
        return r;
    endfunction

    // Advances the state by one beat; returns 1 and the row result when the beat
    // closes a row. A column at or beyond the column count adds nothing and marks
    // the row; an empty-row beat closes whatever is pending.
    function automatic bit matvec_step(input csm_pkg::item_t b,
                                       output csm_pkg::result_t r);
        int unsigned cols;
        r = '0;
        case (b.func)
            csm_pkg::FUNC_LOAD:
            begin
                x_mem[b.vector_index]    = b.vector_value;
                x_loaded[b.vector_index] = 1'b1;
            end
            csm_pkg::FUNC_TERM:
            begin
                cols = (reg_cols > csm_pkg::MAX_COLS) ? csm_pkg::MAX_COLS : reg_cols;
                if (b.column_index >= cols)
                    row_bad_col = 1'b1;
                else
                    acc_q3232 = add_clipped(acc_q3232,
                        longint'(b.matrix_value) * longint'(x_mem[b.column_index]));
                if (b.row_end)
                begin
                    r = close_row_sum();
                    return 1'b1;
                end
            end
            csm_pkg::FUNC_EMPTY:
            begin
                r = close_row_sum();
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic plan_row_t beat_row(input logic [1:0] f,
                                           input logic [csm_pkg::COL_WIDTH-1:0] vi,
                                           input logic [csm_pkg::VALUE_WIDTH-1:0] vv,
                                           input logic [csm_pkg::COL_WIDTH-1:0] ci,
                                           input logic [csm_pkg::VALUE_WIDTH-1:0] mv,
                                           input logic re);
        plan_row_t p;
        p.kind              = STEP_BEAT;
        p.beat.func         = f;
        p.beat.vector_index = vi;
        p.beat.vector_value = vv;
        p.beat.column_index = ci;
        p.beat.matrix_value = mv;
        p.beat.row_end      = re;
        p.reg_sel           = csm_pkg::REG_NUM_ROWS;
        p.reg_val           = '0;
        p.typed             = 1'b0;
        p.want              = '0;
        return p;
    endfunction

    function automatic plan_row_t reg_row(input csm_pkg::reg_index_t sel,
                                          input logic [csm_pkg::CFG_WIDTH-1:0] v);
        plan_row_t p;
        p         = beat_row(csm_pkg::FUNC_EMPTY, '0, '0, '0, '0, 1'b0);
        p.kind    = STEP_REG;
        p.reg_sel = sel;
        p.reg_val = v;
        return p;
    endfunction

    function automatic plan_row_t with_want(input plan_row_t p,
                                            input logic [csm_pkg::ROW_WIDTH-1:0] ri,
                                            input logic [csm_pkg::VALUE_WIDTH-1:0] s,
                                            input logic sat,
                                            input logic err,
                                            input logic last);
        p.typed            = 1'b1;
        p.want.row_index   = ri;
        p.want.row_sum     = s;
        p.want.saturated   = sat;
        p.want.index_error = err;
        p.want.last_row    = last;
        return p;
    endfunction

    // Appends one row to the directed table.
    function automatic void plan_add(input plan_row_t p);
        plan = {plan, p};
    endfunction

    // Gaps between beats: mostly none or short, now and then a long one.
    function automatic int gap_pick(input bit calm);
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Q16.16 values: the two extremes, full random words, and modest magnitudes
    // that keep most sums inside the range.
    function automatic logic [csm_pkg::VALUE_WIDTH-1:0] value_pick();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 32'h6_FFFF)) - 32'h3_8000;
        endcase
    endfunction

    function automatic logic [csm_pkg::CFG_WIDTH-1:0] rows_pick();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return csm_pkg::CFG_WIDTH'(1);
            2:       return '1;
            3:       return csm_pkg::CFG_WIDTH'(csm_pkg::MAX_ROWS);
            4:       return csm_pkg::CFG_WIDTH'($urandom_range(csm_pkg::MAX_ROWS + 1, 8191));
            default: return csm_pkg::CFG_WIDTH'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [csm_pkg::CFG_WIDTH-1:0] cols_pick();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return csm_pkg::CFG_WIDTH'(1);
            2:       return '1;
            3:       return csm_pkg::CFG_WIDTH'(csm_pkg::MAX_COLS);
            4:       return csm_pkg::CFG_WIDTH'($urandom_range(1, csm_pkg::MAX_COLS));
            default: return csm_pkg::CFG_WIDTH'($urandom_range(2, 48));
        endcase
    endfunction

    // A beat with every field random; callers overwrite the fields that matter.
    function automatic csm_pkg::item_t noise_beat();
        csm_pkg::item_t b;
        b.func         = 2'($urandom);
        b.vector_index = csm_pkg::COL_WIDTH'($urandom);
        b.vector_value = $urandom;
        b.column_index = csm_pkg::COL_WIDTH'($urandom);
        b.matrix_value = $urandom;
        b.row_end      = 1'($urandom);
        return b;
    endfunction

    // Offers one beat and holds it until the block takes it. Valid is left high
    // when no gap follows, so that the next call only replaces the payload and a
    // back-to-back stream never drops valid within a time step.
    task automatic send_beat(input csm_pkg::item_t b, input int gap, input bit typed,
                             input csm_pkg::result_t want);
        csm_pkg::result_t r;
        item       <= b;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        if (matvec_step(b, r))
            pending_rows = {pending_rows, (typed ? want : r)};
        if (b.func != FUNC_UNUSED)
            beats_sent++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering beats and lets the block go idle: every owed row has arrived,
    // and beats that close no row have had time to leave the pipeline.
    task automatic quiesce();
        item_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input csm_pkg::reg_index_t sel,
                             input logic [csm_pkg::CFG_WIDTH-1:0] v);
        cfg_index <= sel;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (sel == csm_pkg::REG_NUM_ROWS)
            reg_rows = v;
        else
            reg_cols = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One stretch of random traffic under a fixed register setting. Most of it is
    // whole rows: a handful of terms with the last one marking the row end, or an
    // empty-row beat. Some rows are cut short by an empty-row beat instead of the
    // end mark, and loads and ignored codes are mixed in as noise. A column that is
    // in range but has never been loaded gets a load right before its term, so no term
    // that adds reads a vector entry that has not been written.
    task automatic random_phase(input bit calm);
        int                            start;
        int                            target;
        int                            pick;
        int                            terms;
        int                            cols;
        bit                            broken;
        csm_pkg::item_t                b;
        logic [csm_pkg::COL_WIDTH-1:0] col;
        start  = beats_sent;
        target = $urandom_range(60, 140);
        cols   = (reg_cols > csm_pkg::MAX_COLS) ? csm_pkg::MAX_COLS : reg_cols;
        while (beats_sent - start < target)
        begin
            b    = noise_beat();
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                b.func = FUNC_UNUSED;
                send_beat(b, gap_pick(calm), 1'b0, '0);
            end
            else if (pick < 14)
            begin
                b.func = csm_pkg::FUNC_LOAD;
                if ($urandom_range(0, 1) == 0 && cols > 0)
                    b.vector_index = csm_pkg::COL_WIDTH'($urandom_range(0, cols - 1));
                b.vector_value = value_pick();
                send_beat(b, gap_pick(calm), 1'b0, '0);
            end
            else
            begin
                terms  = $urandom_range(0, 5);
                broken = (terms > 0) && ($urandom_range(0, 9) == 0);
                if (terms == 0)
                begin
                    b.func = csm_pkg::FUNC_EMPTY;
                    send_beat(b, gap_pick(calm), 1'b0, '0);
                end
                for (int k = 0; k < terms; k++)
                begin
                    if (cols == 0 || (cols < csm_pkg::MAX_COLS && $urandom_range(0, 9) == 0))
                        col = csm_pkg::COL_WIDTH'($urandom_range(cols,
                                                                 csm_pkg::MAX_COLS - 1));
                    else
                        col = csm_pkg::COL_WIDTH'($urandom_range(0, cols - 1));
                    if (col < cols && !x_loaded[col])
                    begin
                        b              = noise_beat();
                        b.func         = csm_pkg::FUNC_LOAD;
                        b.vector_index = col;
                        b.vector_value = value_pick();
                        send_beat(b, gap_pick(calm), 1'b0, '0);
                    end
                    b              = noise_beat();
                    b.func         = csm_pkg::FUNC_TERM;
                    b.column_index = col;
                    b.matrix_value = value_pick();
                    b.row_end      = (k == terms - 1) && !broken;
                    send_beat(b, gap_pick(calm), 1'b0, '0);
                end
                if (broken)
                begin
                    b      = noise_beat();
                    b.func = csm_pkg::FUNC_EMPTY;
                    send_beat(b, gap_pick(calm), 1'b0, '0);
                end
            end
        end
    endtask

    // Stimulus: the directed table first, then random phases, each under a fresh
    // register setting written while the block is idle.
    initial
    begin
        int phase;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        beats_sent  = 0;
        squeeze_go  = 1'b0;
        acc_q3232   = 0;
        row_cnt     = 0;
        row_bad_col = 1'b0;
        reg_rows    = csm_pkg::CFG_WIDTH'(csm_pkg::MAX_ROWS);
        reg_cols    = csm_pkg::CFG_WIDTH'(csm_pkg::MAX_COLS);

        // Vector entries at both ends of the index range and at both value extremes,
        // plus the smallest positive step for the rounding checks.
        plan_add(beat_row(csm_pkg::FUNC_LOAD, 12'd0, 32'h0001_0000, '0, '0, 1'b0));
        plan_add(beat_row(csm_pkg::FUNC_LOAD, 12'hFFF, 32'h7FFF_FFFF, '0, '0, 1'b0));
        plan_add(beat_row(csm_pkg::FUNC_LOAD, 12'd1, 32'h8000_0000, '0, '0, 1'b0));
        plan_add(beat_row(csm_pkg::FUNC_LOAD, 12'd3, 32'h0000_0001, '0, '0, 1'b0));
        // An empty row right after reset gives row 0 with a zero sum.
        plan_add(with_want(beat_row(csm_pkg::FUNC_EMPTY, '0, '0, '0, '0, 1'b0),
                           12'd0, 32'h0, 1'b0, 1'b0, 1'b0));
        // One times two.
        plan_add(with_want(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd0, 32'h0002_0000,
                                    1'b1),
                           12'd1, 32'h0002_0000, 1'b0, 1'b0, 1'b0));
        // Largest times largest clips the row sum.
        plan_add(with_want(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'hFFF, 32'h7FFF_FFFF,
                                    1'b1),
                           12'd2, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0));
        // Two products of the most negative values push the accumulator past its
        // top; a negative term then adds to the clipped value.
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd1, 32'h8000_0000, 1'b0));
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd1, 32'h8000_0000, 1'b0));
        plan_add(with_want(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd1, 32'h7FFF_FFFF,
                                    1'b1),
                           12'd3, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0));
        // Three large negative products drive the accumulator past its bottom.
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd1, 32'h7FFF_FFFF, 1'b0));
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd1, 32'h7FFF_FFFF, 1'b0));
        plan_add(with_want(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd1, 32'h7FFF_FFFF,
                                    1'b1),
                           12'd4, 32'h8000_0000, 1'b1, 1'b0, 1'b0));
        // Half an LSB either way: the tie goes toward plus infinity.
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd3, 32'h0000_8000, 1'b1));
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd3, 32'hFFFF_8000, 1'b1));
        // The unused code with every field set does nothing at all.
        plan_add(beat_row(FUNC_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 12'hFFF,
                          32'hFFFF_FFFF, 1'b1));
        // An empty-row beat in the middle of a row closes it with what is pending.
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd0, 32'h0001_0000, 1'b0));
        plan_add(beat_row(csm_pkg::FUNC_EMPTY, '0, '0, '0, '0, 1'b0));
        // With one column, a term at the top column is flagged and adds nothing.
        plan_add(reg_row(csm_pkg::REG_NUM_COLS, 13'd1));
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd0, 32'h0001_0000, 1'b0));
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'hFFF, 32'h7FFF_FFFF, 1'b1));
        // With zero columns every column is flagged.
        plan_add(reg_row(csm_pkg::REG_NUM_COLS, 13'd0));
        plan_add(with_want(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'd0, 32'h0001_0000,
                                    1'b1),
                           12'd9, 32'h0, 1'b0, 1'b1, 1'b0));
        // A row count of zero acts as one. The count is already past it, so the
        // next row keeps its number and the count wraps; after that every row is
        // row 0 and the last one.
        plan_add(reg_row(csm_pkg::REG_NUM_ROWS, 13'd0));
        plan_add(with_want(beat_row(csm_pkg::FUNC_EMPTY, '0, '0, '0, '0, 1'b0),
                           12'd10, 32'h0, 1'b0, 1'b0, 1'b0));
        plan_add(with_want(beat_row(csm_pkg::FUNC_EMPTY, '0, '0, '0, '0, 1'b0),
                           12'd0, 32'h0, 1'b0, 1'b0, 1'b1));
        // Oversize registers act as the maximum sizes.
        plan_add(reg_row(csm_pkg::REG_NUM_ROWS, 13'h1FFF));
        plan_add(reg_row(csm_pkg::REG_NUM_COLS, 13'h1FFF));
        plan_add(beat_row(csm_pkg::FUNC_TERM, '0, '0, 12'hFFF, 32'hFFFF_FFFF, 1'b1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REG)
            begin
                quiesce();
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end
            else
                send_beat(plan[i].beat, gap_pick(1'b0), plan[i].typed, plan[i].want);
        end

        // Random phases until enough beats have gone in. Phase 1 carries the long
        // receiver hold-off and runs with no gaps, so the sender keeps offering
        // while the block backs up.
        phase = 0;
        while (beats_sent < TARGET_BEATS)
        begin
            quiesce();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(csm_pkg::REG_NUM_ROWS, rows_pick());
                write_reg(csm_pkg::REG_NUM_COLS, cols_pick());
            end
            else
            begin
                write_reg(csm_pkg::REG_NUM_COLS, cols_pick());
                write_reg(csm_pkg::REG_NUM_ROWS, rows_pick());
            end
            if (phase == 1)
                squeeze_go = 1'b1;
            random_phase(phase == 1 || $urandom_range(0, 3) == 0);
            phase++;
        end

        quiesce();
        if (bad_results == 0)
            $display("csr_sparse_matvec_tb: PASS");
        else
            $display("csr_sparse_matvec_tb: FAIL");
        $finish;
    end

    // Result side: checks each accepted beat against the oldest owed row, then
    // picks the stall for the next cycle. Stalls come in runs: short bursts, rare
    // long ones, and long stretches with none. Once, on request, it holds off for
    // a long stretch counted here so that the block fills and stalls its input.
    initial
    begin
        csm_pkg::result_t want;
        int               run;
        int               hold;
        int               pick;
        bit               stall_mode;
        bit               stall_now;
        bit               squeeze_done;
        result_stall = 1'b0;
        bad_results  = 0;
        run          = 0;
        hold         = 0;
        stall_mode   = 1'b0;
        squeeze_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (pending_rows.size() == 0)
                begin
                    if (bad_results < REPORT_LIMIT)
                        $display("unexpected result beat: row %0d sum %h sat %b err %b last %b",
                                 result.row_index, result.row_sum, result.saturated,
                                 result.index_error, result.last_row);
                    bad_results++;
                end
                else
                begin
                    want = pending_rows.pop_front();
                    if (result.row_index !== want.row_index ||
                        result.row_sum !== want.row_sum ||
                        result.saturated !== want.saturated ||
                        result.index_error !== want.index_error ||
                        result.last_row !== want.last_row)
                    begin
                        if (bad_results < REPORT_LIMIT)
                            $display({"row mismatch: expected row %0d sum %h sat %b err %b ",
                                      "last %b, got row %0d sum %h sat %b err %b last %b"},
                                     want.row_index, want.row_sum, want.saturated,
                                     want.index_error, want.last_row,
                                     result.row_index, result.row_sum, result.saturated,
                                     result.index_error, result.last_row);
                        bad_results++;
                    end
                end
            end

            if (hold > 0)
            begin
                hold--;
                stall_now = 1'b1;
            end
            else if (squeeze_go && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                hold         = SQUEEZE_CYCLES - 1;
                stall_now    = 1'b1;
            end
            else
            begin
                if (run == 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                    begin
                        stall_mode = 1'b0;
                        run        = $urandom_range(1, 8);
                    end
                    else if (pick < 65)
                    begin
                        stall_mode = 1'b0;
                        run        = $urandom_range(30, 120);
                    end
                    else if (pick < 93)
                    begin
                        stall_mode = 1'b1;
                        run        = $urandom_range(1, 3);
                    end
                    else
                    begin
                        stall_mode = 1'b1;
                        run        = $urandom_range(10, 60);
                    end
                end
                run--;
                stall_now = stall_mode;
            end
            result_stall <= stall_now;
        end
    end

    // Watchdog: a run that hangs ends here.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("csr_sparse_matvec_tb: FAIL");
        $finish;
    end

endmodule
